// ----- src/pcm_frame_downmix_assert.svh -----
// Assertion helpers for the frame downmix block.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef PCM_FRAME_DOWNMIX_ASSERT_SVH
`define PCM_FRAME_DOWNMIX_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pfd_pkg.sv -----
`default_nettype none

package pfd_pkg;

  // Sample format codes
  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_S16 = 3'd1;
  localparam logic [2:0] FMT_S24 = 3'd2;
  localparam logic [2:0] FMT_S32 = 3'd3;
  localparam logic [2:0] FMT_F32 = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd1;

  // Register reset values
  localparam logic [2:0] FMT_RESET   = FMT_S16;
  localparam logic [3:0] CHAN_RESET  = 4'd1;

  // Controller to datapath
  typedef struct packed {
    logic take_sample;
    logic add_sample;
    logic load_div;
    logic div_step;
    logic apply_sign;
    logic push;
  } pfd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_last;
    logic div_last;
  } pfd_sts_t;

endpackage

`default_nettype wire

// ----- src/pfd_ctrl.sv -----
`default_nettype none

`include "pcm_frame_downmix_assert.svh"

module pfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pfd_pkg::pfd_sts_t sts,
  output pfd_pkg::pfd_cmd_t cmd
);
  import pfd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SIGN = 3'd4;
  localparam logic [2:0] ST_PUSH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       push_ok;

  assign push_ok   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_sample = 1'b1;
          state_nxt       = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_sample = 1'b1;
        state_nxt      = sts.frame_last ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        cmd.load_div = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        cmd.apply_sign = 1'b1;
        state_nxt      = ST_PUSH;
      end
      ST_PUSH: begin
        if (push_ok) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PFD_ASSERT_NEXT(a_push_waits, state_r == ST_PUSH && out_valid_r && !out_ready,
                   state_r == ST_PUSH && out_valid_r, "result pushed over a pending transfer")
  `PFD_ASSERT_NEXT(a_last_loads, state_r == ST_ADD && sts.frame_last,
                   state_r == ST_LOAD, "frame end did not start the divide")
  `PFD_ASSERT_SAME(a_no_take_busy, state_r != ST_IDLE,
                   !in_ready && !cmd.take_sample, "sample taken while busy")

endmodule

`default_nettype wire

// ----- src/pfd_dpath.sv -----
`default_nettype none

`include "pcm_frame_downmix_assert.svh"

module pfd_dpath #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pfd_pkg::pfd_cmd_t                 cmd,
  output pfd_pkg::pfd_sts_t                 sts,
  input  logic                              cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [31:0]                       in_sample_word,
  output logic signed [31:0]                out_mono_sample,
  output logic                              out_bad_frame
);
  import pfd_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W  = 33 + $clog2(MAX_CHANNELS);
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam logic [4:0] MAX_C = 5'(MAX_CHANNELS);

  // Configuration
  logic [2:0]       fmt_r;
  logic [3:0]       chan_r;
  logic [CNT_W-1:0] n_eff;

  // Accumulation
  logic signed [31:0]      conv_val, conv_r;
  logic                    conv_bad, conv_bad_r;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    bad_r;
  logic [CNT_W-1:0]        pos_r;
  logic [CNT_W:0]          pos_inc;

  // Divide
  logic [CNT_W-1:0]  div_r, rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic              neg_r, bad_div_r;
  logic [CNT_W:0]    trial, diff;
  logic              ge;

  // Output
  logic signed [31:0] mono_r, sat_val;
  logic               bad_out_r;
  logic [SUM_W-32:0]  hi_bits;

  // Float decode
  logic [7:0]  f_exp, f_exp_eff, f_rsh;
  logic [30:0] f_ext;
  logic [31:0] f_mag;
  logic [31:0] f_val;

  always_comb begin
    if (chan_r == 4'd0) begin
      n_eff = CNT_W'(1);
    end else if ({1'b0, chan_r} > MAX_C) begin
      n_eff = CNT_W'(MAX_C);
    end else begin
      n_eff = CNT_W'(chan_r);
    end
  end

  // Float32 to Q2.30: one right shift of the mantissa aligned at 2^7
  always_comb begin
    f_exp     = in_sample_word[30:23];
    f_exp_eff = (f_exp == 8'd0) ? 8'd1 : f_exp;
    f_ext     = {(f_exp != 8'd0), in_sample_word[22:0], 7'd0};
    f_rsh     = 8'd127 - f_exp_eff;
    if (f_exp_eff >= 8'd128) begin
      f_mag = 32'h8000_0000;
    end else begin
      f_mag = {1'b0, f_ext >> f_rsh};
    end
    if (in_sample_word[31]) begin
      f_val = -f_mag;
    end else if (f_mag[31]) begin
      f_val = 32'h7fff_ffff;
    end else begin
      f_val = f_mag;
    end
  end

  always_comb begin
    conv_bad = 1'b0;
    unique case (fmt_r)
      FMT_U8:  conv_val = {~in_sample_word[7], ~in_sample_word[7], in_sample_word[6:0], 23'd0};
      FMT_S16: conv_val = {in_sample_word[15], in_sample_word[15:0], 15'd0};
      FMT_S24: conv_val = {in_sample_word[23], in_sample_word[23:0], 7'd0};
      FMT_S32: conv_val = {in_sample_word[31], in_sample_word[31:1]};
      FMT_F32: begin
        if (f_exp == 8'hff) begin
          conv_val = '0;
          conv_bad = 1'b1;
        end else begin
          conv_val = f_val;
        end
      end
      default: conv_val = '0;
    endcase
  end

  assign sum_nxt        = sum_r + {{(SUM_W-32){conv_r[31]}}, conv_r};
  assign pos_inc        = {1'b0, pos_r} + (CNT_W+1)'(1);
  assign sts.frame_last = pos_inc >= {1'b0, n_eff};

  // Restoring divide, one quotient bit per step
  assign trial        = {rem_r, quo_r[SUM_W-1]};
  assign ge           = trial >= {1'b0, div_r};
  assign diff         = trial - {1'b0, div_r};
  assign sts.div_last = step_r == STEP_W'(1);

  assign hi_bits = quo_r[SUM_W-1:31];
  always_comb begin
    if (&hi_bits || ~|hi_bits) begin
      sat_val = quo_r[31:0];
    end else if (quo_r[SUM_W-1]) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= FMT_RESET;
      chan_r <= CHAN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SAMPLE_FORMAT) begin
        fmt_r <= cfg_wdata[2:0];
      end
      if (cfg_index == CFG_CHANNEL_COUNT) begin
        chan_r <= cfg_wdata[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      bad_r <= 1'b0;
      pos_r <= '0;
    end else if (cmd.add_sample) begin
      sum_r <= sum_nxt;
      bad_r <= bad_r | conv_bad_r;
      pos_r <= sts.frame_last ? '0 : pos_inc[CNT_W-1:0];
    end else if (cmd.load_div) begin
      sum_r <= '0;
      bad_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      conv_r     <= conv_val;
      conv_bad_r <= conv_bad;
    end
    if (cmd.add_sample && sts.frame_last) begin
      div_r <= n_eff;
    end
    if (cmd.load_div) begin
      neg_r     <= sum_r[SUM_W-1];
      quo_r     <= sum_r[SUM_W-1] ? -sum_r : sum_r;
      rem_r     <= '0;
      step_r    <= STEP_W'(SUM_W);
      bad_div_r <= bad_r;
    end else if (cmd.div_step) begin
      rem_r  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      step_r <= step_r - STEP_W'(1);
    end else if (cmd.apply_sign && neg_r) begin
      quo_r <= -quo_r;
    end
    if (cmd.push) begin
      mono_r    <= sat_val;
      bad_out_r <= bad_div_r;
    end
  end

  assign out_mono_sample = mono_r;
  assign out_bad_frame   = bad_out_r;

  `PFD_ASSERT_SAME(a_rem_below_div, cmd.div_step,
                   div_r != '0 && rem_r < div_r, "divide remainder out of range")
  `PFD_ASSERT_NEXT(a_frame_restart, cmd.add_sample && sts.frame_last,
                   pos_r == '0, "channel position not restarted at frame end")

endmodule

`default_nettype wire

// ----- src/pcm_frame_downmix.sv -----
// Result valid once a frame's last sample is added, divided (SUM_W quotient bits, SUM_W =
//   33 + clog2(MAX_CHANNELS)), signed and pushed; later if out is stalled.
// A new sample is taken only after the last one is added, and a new frame only after the
//   result is pushed; the divide by the channel count yields one quotient bit per cycle.
// Reset (rst_n, synchronous): format s16, one channel, empty frame sum, no result pending.
`default_nettype none

module pcm_frame_downmix #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Sample input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [31:0]                    in_sample_word,
  // Mono result
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             out_mono_sample,
  output logic                           out_bad_frame,
  // Register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pfd_pkg::*;

  pfd_cmd_t cmd;
  pfd_sts_t sts;

  // Registers take a write in any cycle; it is up to software that it only writes between
  // frames or with no result outstanding; the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  // Controller: one sample transfer, then the add; at frame end it runs the
  // load / divide / sign / push sequence and holds the result until its transfer.
  pfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: format conversion to Q2.30, frame accumulator, serial divider
  // and the saturating output register.
  pfd_dpath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_sample_word  (in_sample_word),
    .out_mono_sample (out_mono_sample),
    .out_bad_frame   (out_bad_frame)
  );

endmodule

`default_nettype wire
